FILE: rtl/c6502_pkg.sv
// Package for the 6502 load/store subset unit: request codes, sequencer
// states, decode kinds and modes. No dependencies.
package c6502_pkg;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_RESET = 2'd2,
      REQ_EXEC  = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_TAX, K_TAY,
      K_TXA, K_TYA, K_INX, K_INY, K_DEX, K_DEY, K_INC, K_DEC
   } kind_type;

   typedef enum logic [3:0] {
      M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,    // waiting for an item
      ST_RDWAIT,  // plain memory read in flight
      ST_VECLO,   // reset vector low byte in flight
      ST_VECHI,   // reset vector high byte in flight
      ST_OPC,     // opcode fetch in flight
      ST_OPR1,    // first operand byte in flight
      ST_OPR2,    // second operand byte in flight
      ST_PTRLO,   // pointer low byte in flight
      ST_PTRHI,   // pointer high byte in flight
      ST_DATA,    // data byte in flight
      ST_WB,      // read-modify-write store cycle
      ST_DONE     // result waiting to be taken
   } state_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      mode_type mode;
   } decode_type;

   localparam logic [15:0] RESET_VEC = 16'hFFFC;
   localparam logic [7:0]  SIGN_BIT  = 8'b1000_0000;

   function automatic decode_type decode(input logic [7:0] op);
      decode_type d;
      d = '{valid: 1'b1, kind: K_LDA, mode: M_IMP};
      unique case (op)
         8'hA9: begin d.kind = K_LDA; d.mode = M_IMM;  end
         8'hA5: begin d.kind = K_LDA; d.mode = M_ZP;   end
         8'hB5: begin d.kind = K_LDA; d.mode = M_ZPX;  end
         8'hAD: begin d.kind = K_LDA; d.mode = M_ABS;  end
         8'hBD: begin d.kind = K_LDA; d.mode = M_ABSX; end
         8'hB9: begin d.kind = K_LDA; d.mode = M_ABSY; end
         8'hA1: begin d.kind = K_LDA; d.mode = M_INDX; end
         8'hB1: begin d.kind = K_LDA; d.mode = M_INDY; end
         8'hA2: begin d.kind = K_LDX; d.mode = M_IMM;  end
         8'hA6: begin d.kind = K_LDX; d.mode = M_ZP;   end
         8'hB6: begin d.kind = K_LDX; d.mode = M_ZPY;  end
         8'hAE: begin d.kind = K_LDX; d.mode = M_ABS;  end
         8'hBE: begin d.kind = K_LDX; d.mode = M_ABSY; end
         8'hA0: begin d.kind = K_LDY; d.mode = M_IMM;  end
         8'hA4: begin d.kind = K_LDY; d.mode = M_ZP;   end
         8'hB4: begin d.kind = K_LDY; d.mode = M_ZPX;  end
         8'hAC: begin d.kind = K_LDY; d.mode = M_ABS;  end
         8'hBC: begin d.kind = K_LDY; d.mode = M_ABSX; end
         8'h85: begin d.kind = K_STA; d.mode = M_ZP;   end
         8'h95: begin d.kind = K_STA; d.mode = M_ZPX;  end
         8'h8D: begin d.kind = K_STA; d.mode = M_ABS;  end
         8'h9D: begin d.kind = K_STA; d.mode = M_ABSX; end
         8'h99: begin d.kind = K_STA; d.mode = M_ABSY; end
         8'h81: begin d.kind = K_STA; d.mode = M_INDX; end
         8'h91: begin d.kind = K_STA; d.mode = M_INDY; end
         8'h86: begin d.kind = K_STX; d.mode = M_ZP;   end
         8'h96: begin d.kind = K_STX; d.mode = M_ZPY;  end
         8'h8E: begin d.kind = K_STX; d.mode = M_ABS;  end
         8'h84: begin d.kind = K_STY; d.mode = M_ZP;   end
         8'h94: begin d.kind = K_STY; d.mode = M_ZPX;  end
         8'h8C: begin d.kind = K_STY; d.mode = M_ABS;  end
         8'hAA: d.kind = K_TAX;
         8'hA8: d.kind = K_TAY;
         8'h8A: d.kind = K_TXA;
         8'h98: d.kind = K_TYA;
         8'hE8: d.kind = K_INX;
         8'hC8: d.kind = K_INY;
         8'hCA: d.kind = K_DEX;
         8'h88: d.kind = K_DEY;
         8'hC6: begin d.kind = K_DEC; d.mode = M_ZP;   end
         8'hD6: begin d.kind = K_DEC; d.mode = M_ZPX;  end
         8'hCE: begin d.kind = K_DEC; d.mode = M_ABS;  end
         8'hDE: begin d.kind = K_DEC; d.mode = M_ABSX; end
         8'hE6: begin d.kind = K_INC; d.mode = M_ZP;   end
         8'hF6: begin d.kind = K_INC; d.mode = M_ZPX;  end
         8'hEE: begin d.kind = K_INC; d.mode = M_ABS;  end
         8'hFE: begin d.kind = K_INC; d.mode = M_ABSX; end
         default: d.valid = 1'b0;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/c6502_if.sv
// Valid/ready channel interfaces for the 6502 subset unit.
// Depends on nothing.
interface c6502_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] mem_addr;
   logic [7:0]  wr_data;
   modport source (output valid, req_type, mem_addr, wr_data, input ready);
   modport sink   (input valid, req_type, mem_addr, wr_data, output ready);
endinterface

interface c6502_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rd_data;
   logic [7:0]  acc;
   logic [7:0]  x_reg;
   logic [7:0]  y_reg;
   logic [15:0] prog_ctr;
   logic        neg_flag;
   logic        zero_flag;
   logic        bad_opcode;
   modport source (output valid, rd_data, acc, x_reg, y_reg, prog_ctr, neg_flag,
                   zero_flag, bad_opcode, input ready);
   modport sink   (input valid, rd_data, acc, x_reg, y_reg, prog_ctr, neg_flag,
                   zero_flag, bad_opcode, output ready);
endinterface

FILE: rtl/c6502_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module c6502_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

FILE: rtl/cpu_6502_load_store_subset_unit.sv
// Top level of the 6502 load/store subset unit: sequencer, registers, memory.
// Depends on c6502_pkg, c6502_if.sv and c6502_ram.
//
// channel  dir  handshake      payload
// req_     in   valid/ready    req_type, mem_addr, wr_data
// rsp_     out  valid/ready    rd_data, acc, x_reg, y_reg, prog_ctr, flags
//
// One item at a time through one single-port RAM, one access per cycle.
// A write completes from idle; a read waits on the registered RAM output; core
// reset reads both vector bytes. Execute length is set by the chain of dependent
// memory accesses (indirect modes and absolute read-modify-write are longest).
// Result sits in the output register; the next item is taken once it leaves.
// Reset is synchronous; memory contents are not cleared.
module cpu_6502_load_store_subset_unit #(
   parameter int ADDR_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   c6502_req_if.sink    req,
   c6502_rsp_if.source  rsp
);
   c6502_pkg::state_type   state_ff, state_in;
   c6502_pkg::decode_type  dec_ff, dec_in;
   logic [ADDR_BITS-1:0]   pc_ff, pc_in, ea_ff, ea_in;
   logic [7:0]             a_ff, a_in, x_ff, x_in, y_ff, y_in, tmp_ff, tmp_in;
   logic [7:0]             rd_ff, rd_in;
   logic                   n_ff, n_in, z_ff, z_in, bad_ff, bad_in;

   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_addr;
   logic [7:0]             mem_wd, mem_rd;

   c6502_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_ram (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wd), .rd_data(mem_rd)
   );

   assign req.ready      = (state_ff == c6502_pkg::ST_IDLE);
   assign rsp.valid      = (state_ff == c6502_pkg::ST_DONE);
   assign rsp.rd_data    = rd_ff;
   assign rsp.acc        = a_ff;
   assign rsp.x_reg      = x_ff;
   assign rsp.y_reg      = y_ff;
   assign rsp.prog_ctr   = pc_ff;
   assign rsp.neg_flag   = n_ff;
   assign rsp.zero_flag  = z_ff;
   assign rsp.bad_opcode = bad_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= c6502_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // architectural and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0; a_ff <= '0; x_ff <= '0; y_ff <= '0;
         n_ff <= 1'b0; z_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in; a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         n_ff <= n_in; z_ff <= z_in;
      end
      dec_ff <= dec_in; ea_ff <= ea_in; tmp_ff <= tmp_in;
      rd_ff <= rd_in; bad_ff <= bad_in;
   end

   // sequencer
   always_comb begin
      c6502_pkg::decode_type d;
      logic [7:0]            val;
      logic [ADDR_BITS-1:0]  pc1;
      state_in = state_ff;
      dec_in = dec_ff; ea_in = ea_ff; tmp_in = tmp_ff; rd_in = rd_ff;
      bad_in = bad_ff;
      pc_in = pc_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff;
      n_in = n_ff; z_in = z_ff;
      mem_we = 1'b0; mem_addr = pc_ff; mem_wd = a_ff;
      d = c6502_pkg::decode(mem_rd);
      val = 8'd0;
      pc1 = pc_ff + 1'b1;
      unique case (state_ff)
         c6502_pkg::ST_IDLE: begin
            rd_in = 8'd0; bad_in = 1'b0;
            if (req.valid) begin
               unique case (c6502_pkg::req_code_type'(req.req_type))
                  c6502_pkg::REQ_WRITE: begin
                     mem_we = 1'b1; mem_addr = req.mem_addr; mem_wd = req.wr_data;
                     state_in = c6502_pkg::ST_DONE;
                  end
                  c6502_pkg::REQ_READ: begin
                     mem_addr = req.mem_addr; state_in = c6502_pkg::ST_RDWAIT;
                  end
                  c6502_pkg::REQ_RESET: begin
                     mem_addr = c6502_pkg::RESET_VEC; state_in = c6502_pkg::ST_VECLO;
                  end
                  c6502_pkg::REQ_EXEC: begin
                     mem_addr = pc_ff; pc_in = pc1; state_in = c6502_pkg::ST_OPC;
                  end
               endcase
            end
         end
         c6502_pkg::ST_RDWAIT: begin
            rd_in = mem_rd; state_in = c6502_pkg::ST_DONE;
         end
         c6502_pkg::ST_VECLO: begin
            tmp_in = mem_rd; mem_addr = c6502_pkg::RESET_VEC + 1'b1;
            state_in = c6502_pkg::ST_VECHI;
         end
         c6502_pkg::ST_VECHI: begin
            pc_in = {mem_rd, tmp_ff};
            a_in = '0; x_in = '0; y_in = '0; n_in = 1'b0; z_in = 1'b0;
            state_in = c6502_pkg::ST_DONE;
         end
         c6502_pkg::ST_OPC: begin
            dec_in = d;
            if (!d.valid) begin
               bad_in = 1'b1; state_in = c6502_pkg::ST_DONE;
            end else if (d.mode == c6502_pkg::M_IMP) begin
               state_in = c6502_pkg::ST_DONE;
               unique case (d.kind)
                  c6502_pkg::K_TAX: begin x_in = a_ff; val = a_ff; end
                  c6502_pkg::K_TAY: begin y_in = a_ff; val = a_ff; end
                  c6502_pkg::K_TXA: begin a_in = x_ff; val = x_ff; end
                  c6502_pkg::K_TYA: begin a_in = y_ff; val = y_ff; end
                  c6502_pkg::K_INX: begin val = x_ff + 8'd1; x_in = val; end
                  c6502_pkg::K_INY: begin val = y_ff + 8'd1; y_in = val; end
                  c6502_pkg::K_DEX: begin val = x_ff - 8'd1; x_in = val; end
                  default:          begin val = y_ff - 8'd1; y_in = val; end
               endcase
               n_in = val[7]; z_in = (val == 8'd0);
            end else begin
               mem_addr = pc_ff; pc_in = pc1; state_in = c6502_pkg::ST_OPR1;
            end
         end
         c6502_pkg::ST_OPR1: begin
            tmp_in = mem_rd;
            priority case (dec_ff.mode)
               c6502_pkg::M_IMM: begin
                  val = mem_rd; state_in = c6502_pkg::ST_DONE;
                  n_in = val[7]; z_in = (val == 8'd0);
                  if (dec_ff.kind == c6502_pkg::K_LDA) a_in = val;
                  else if (dec_ff.kind == c6502_pkg::K_LDX) x_in = val;
                  else y_in = val;
               end
               c6502_pkg::M_ABS, c6502_pkg::M_ABSX, c6502_pkg::M_ABSY: begin
                  mem_addr = pc_ff; pc_in = pc1; state_in = c6502_pkg::ST_OPR2;
               end
               c6502_pkg::M_INDX: begin
                  ea_in = {{(ADDR_BITS-8){1'b0}}, mem_rd + x_ff};
                  mem_addr = ea_in; state_in = c6502_pkg::ST_PTRLO;
               end
               c6502_pkg::M_INDY: begin
                  ea_in = {{(ADDR_BITS-8){1'b0}}, mem_rd};
                  mem_addr = ea_in; state_in = c6502_pkg::ST_PTRLO;
               end
               default: begin
                  // zero page, zero page indexed
                  if (dec_ff.mode == c6502_pkg::M_ZPX) val = mem_rd + x_ff;
                  else if (dec_ff.mode == c6502_pkg::M_ZPY) val = mem_rd + y_ff;
                  else val = mem_rd;
                  ea_in = {{(ADDR_BITS-8){1'b0}}, val};
                  mem_addr = ea_in; state_in = c6502_pkg::ST_DATA;
               end
            endcase
         end
         c6502_pkg::ST_OPR2: begin
            ea_in = {mem_rd, tmp_ff};
            if (dec_ff.mode == c6502_pkg::M_ABSX) ea_in = ea_in + x_ff;
            else if (dec_ff.mode == c6502_pkg::M_ABSY) ea_in = ea_in + y_ff;
            mem_addr = ea_in; state_in = c6502_pkg::ST_DATA;
         end
         c6502_pkg::ST_PTRLO: begin
            tmp_in = mem_rd;
            mem_addr = {{(ADDR_BITS-8){1'b0}}, ea_ff[7:0] + 8'd1};
            state_in = c6502_pkg::ST_PTRHI;
         end
         c6502_pkg::ST_PTRHI: begin
            ea_in = {mem_rd, tmp_ff};
            if (dec_ff.mode == c6502_pkg::M_INDY) ea_in = ea_in + y_ff;
            mem_addr = ea_in; state_in = c6502_pkg::ST_DATA;
         end
         c6502_pkg::ST_DATA: begin
            // the data read was issued; stores write now instead
            mem_addr = ea_ff; state_in = c6502_pkg::ST_DONE;
            unique case (dec_ff.kind)
               c6502_pkg::K_STA: begin mem_we = 1'b1; mem_wd = a_ff; end
               c6502_pkg::K_STX: begin mem_we = 1'b1; mem_wd = x_ff; end
               c6502_pkg::K_STY: begin mem_we = 1'b1; mem_wd = y_ff; end
               c6502_pkg::K_INC, c6502_pkg::K_DEC: begin
                  val = (dec_ff.kind == c6502_pkg::K_INC) ? mem_rd + 8'd1
                                                         : mem_rd - 8'd1;
                  tmp_in = val; n_in = val[7]; z_in = (val == 8'd0);
                  state_in = c6502_pkg::ST_WB;
               end
               default: begin
                  val = mem_rd; n_in = val[7]; z_in = (val == 8'd0);
                  if (dec_ff.kind == c6502_pkg::K_LDA) a_in = val;
                  else if (dec_ff.kind == c6502_pkg::K_LDX) x_in = val;
                  else y_in = val;
               end
            endcase
         end
         c6502_pkg::ST_WB: begin
            mem_we = 1'b1; mem_addr = ea_ff; mem_wd = tmp_ff;
            state_in = c6502_pkg::ST_DONE;
         end
         c6502_pkg::ST_DONE: begin
            if (rsp.ready) state_in = c6502_pkg::ST_IDLE;
         end
         default: state_in = c6502_pkg::ST_IDLE;
      endcase
   end

   // the accumulator and program counter hold while the result is stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.acc) && $stable(rsp.prog_ctr))
      else $error("result changed while stalled");
   // memory is written only from idle, store, or write-back cycles
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == c6502_pkg::ST_IDLE || state_ff == c6502_pkg::ST_DATA ||
                 state_ff == c6502_pkg::ST_WB)
      else $error("unexpected memory write");
   // an accepted item leaves idle
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("item accepted but still idle");
   // bad opcode only flagged with no read data
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_opcode |-> rsp.rd_data == 8'd0)
      else $error("bad opcode with read data");
endmodule
